>>> design/lhst_pkg.sv
// shared types, constants and register/action codes for the lock hold statistics table
package lhst_pkg;

    localparam int LOCK_SLOTS_DEF = 16;
    localparam int DATA_W         = 32;
    localparam int DIV_CNT_W      = $clog2(DATA_W);
    localparam int SLOT_FIELD_W   = 4;
    localparam int ADDR_SLOTS     = 16;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 168;
    localparam int M_TUSER_W = 1;
    localparam int CFG_ADDR_W = 1;

    localparam logic [7:0]        STALL_FACTOR_RST = 8'd10;
    localparam logic [DATA_W-1:0] STALL_MIN_RST    = 32'd1000000;
    localparam logic [DATA_W-1:0] PCT_SCALE        = 32'd100;

    typedef enum logic [2:0] {
        ACT_REGISTER   = 3'd0,
        ACT_ACQUIRE    = 3'd1,
        ACT_RELEASE    = 3'd2,
        ACT_CONTENTION = 3'd3,
        ACT_REPORT     = 3'd4
    } action_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_STALL_FACTOR = 1'b0,
        CFG_STALL_MIN    = 1'b1
    } cfg_index_t;

    // one table row, everything but the valid and held flags
    typedef struct packed {
        logic [DATA_W-1:0] acquired_at;
        logic [DATA_W-1:0] acq_count;
        logic [DATA_W-1:0] con_count;
        logic [DATA_W-1:0] max_hold;
        logic [DATA_W-1:0] hold_sum;
    } slot_row_t;

endpackage

>>> design/lock_hold_statistics_table.sv
// lock hold statistics table: slot table, event sequencer and report engine
//
//  channel  | ports                          | payload, lowest bit first
//  ---------+--------------------------------+------------------------------------------
//  input    | s_tvalid s_tready s_tdata/user | tuser: action; tdata: lock_slot, now_time
//  result   | m_tvalid m_tready m_tdata/last | tuser: slot_present; tlast: final_item
//  config   | cfg_wr_en cfg_addr cfg_wdata   | 0 stall_factor, 1 stall_min_cycles
//
//  events pass S_EVENT; a release that records a hold time goes on through S_REL
//  a report passes S_SCAN to S_EMIT per registered slot, S_SCAN only per skipped slot;
//  the shared restoring divider runs 32 steps each for mean and percentage
//  reset is synchronous, active low; the table rows need no clearing pass
//  a result waits in the output register; the sequencer stalls only when it
//  has a new result to load while the previous one is still untaken
module lock_hold_statistics_table #(
    parameter int LOCK_SLOTS = lhst_pkg::LOCK_SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // lock_slot[3:0], now_time[35:4], zero fill
    input  logic [lhst_pkg::S_TDATA_W-1:0]  s_tdata,
    // action[2:0]
    input  logic [lhst_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // slot_index[3:0], held_now[4], acquire_total[36:5], contention_total[68:37],
    // longest_hold[100:69], mean_hold[132:101], contention_percent[164:133],
    // stall_suspect[165], zero fill
    output logic [lhst_pkg::M_TDATA_W-1:0]  m_tdata,
    // slot_present[0]
    output logic [lhst_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [lhst_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lhst_pkg::DATA_W-1:0]     cfg_wdata
);
    import lhst_pkg::*;

    localparam int SLOT_W   = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
    localparam int REPORT_N = (LOCK_SLOTS < ADDR_SLOTS) ? LOCK_SLOTS : ADDR_SLOTS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVENT,
        S_REL,
        S_SCAN,
        S_LOAD,
        S_DIV_MEAN,
        S_DIV_PCT,
        S_EMIT,
        S_EMPTY
    } state_t;

    state_t state_reg;

    logic [7:0]        factor_reg;
    logic [DATA_W-1:0] min_reg;

    logic [LOCK_SLOTS-1:0] valid_reg;
    logic [LOCK_SLOTS-1:0] held_reg;

    slot_row_t slot_mem [LOCK_SLOTS];
    slot_row_t row_reg;
    logic      mem_we;
    logic [SLOT_W-1:0] mem_wa;
    slot_row_t mem_wd;
    logic      rd_en;
    logic [SLOT_W-1:0] rd_addr;

    // latched event
    action_t           action_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              slot_ok_reg;
    logic [DATA_W-1:0] now_reg;
    logic [DATA_W-1:0] hold_reg;

    // report engine
    logic [SLOT_W-1:0]    idx_reg;
    logic [DATA_W-1:0]    pct_num_reg;
    logic [DATA_W-1:0]    limit_reg;
    logic [DATA_W-1:0]    dur_reg;
    logic [DATA_W-1:0]    mean_reg;
    logic [DATA_W-1:0]    pct_reg;
    logic                 suspect_reg;
    logic                 held_cur_reg;

    // shared divider
    logic [DATA_W-1:0]    rem_reg;
    logic [DATA_W-1:0]    quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DATA_W+1:0]    div_diff;
    logic [DATA_W-1:0]    rem_next;
    logic [DATA_W-1:0]    quo_next;
    logic                 div_last;

    // output register
    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;
    logic                  out_present_reg;
    logic                  out_last_reg;
    logic                  out_free;
    logic                  out_load;

    logic                  in_xfer;
    logic [SLOT_FIELD_W-1:0] in_slot;
    logic                  in_slot_ok;
    logic                  any_valid;
    logic                  more_after;
    logic                  ev_ok;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign in_slot  = s_tdata[SLOT_FIELD_W-1:0];
    assign in_slot_ok = (32'(in_slot) < LOCK_SLOTS);
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = out_free && ((state_reg == S_EMIT) || (state_reg == S_EMPTY));
    assign ev_ok    = slot_ok_reg && valid_reg[slot_reg];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_present_reg;
    assign m_tlast  = out_last_reg;

    assign any_valid = |valid_reg[REPORT_N-1:0];

    always_comb begin
        more_after = 1'b0;
        for (int i = 0; i < REPORT_N; i++) begin
            if (i > int'(idx_reg) && valid_reg[i]) begin
                more_after = 1'b1;
            end
        end
    end

    // one restoring step: shift in the next dividend bit, try subtracting the count
    assign div_diff = {1'b0, rem_reg, quo_reg[DATA_W-1]} - {2'b00, row_reg.acq_count};
    assign rem_next = div_diff[DATA_W+1] ? {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]}
                                         : div_diff[DATA_W-1:0];
    assign quo_next = {quo_reg[DATA_W-2:0], !div_diff[DATA_W+1]};
    assign div_last = (cnt_reg == DIV_CNT_W'(DATA_W - 1));

    // table read address and write port
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = idx_reg;
        if (in_xfer) begin
            rd_en   = 1'b1;
            rd_addr = SLOT_W'(in_slot);
        end else if (state_reg == S_SCAN) begin
            rd_en   = valid_reg[idx_reg];
        end

        mem_we = 1'b0;
        mem_wa = slot_reg;
        mem_wd = row_reg;
        if (state_reg == S_EVENT) begin
            unique case (action_reg)
                ACT_REGISTER: begin
                    mem_we = slot_ok_reg && !valid_reg[slot_reg];
                    mem_wd = '0;
                end
                ACT_ACQUIRE: begin
                    mem_we = ev_ok;
                    mem_wd.acquired_at = now_reg;
                    mem_wd.acq_count   = row_reg.acq_count + DATA_W'(1);
                end
                ACT_CONTENTION: begin
                    mem_we = ev_ok;
                    mem_wd.con_count = row_reg.con_count + DATA_W'(1);
                end
                default: begin
                    mem_we = 1'b0;
                end
            endcase
        end else if (state_reg == S_REL) begin
            mem_we = 1'b1;
            mem_wd.hold_sum = row_reg.hold_sum + hold_reg;
            if (hold_reg > row_reg.max_hold) begin
                mem_wd.max_hold = hold_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            row_reg <= slot_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            factor_reg    <= STALL_FACTOR_RST;
            min_reg       <= STALL_MIN_RST;
            valid_reg     <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index_t'(cfg_addr))
                    CFG_STALL_FACTOR: factor_reg <= cfg_wdata[7:0];
                    CFG_STALL_MIN:    min_reg    <= cfg_wdata;
                    default:          ;
                endcase
            end

            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (in_xfer) begin
                        action_reg  <= action_t'(s_tuser);
                        slot_reg    <= SLOT_W'(in_slot);
                        slot_ok_reg <= in_slot_ok;
                        now_reg     <= s_tdata[SLOT_FIELD_W +: DATA_W];
                        idx_reg     <= '0;
                        if (action_t'(s_tuser) == ACT_REPORT) begin
                            state_reg <= any_valid ? S_SCAN : S_EMPTY;
                        end else begin
                            state_reg <= S_EVENT;
                        end
                    end
                end
                S_EVENT: begin
                    state_reg <= S_IDLE;
                    unique case (action_reg)
                        ACT_REGISTER: begin
                            if (slot_ok_reg && !valid_reg[slot_reg]) begin
                                valid_reg[slot_reg] <= 1'b1;
                                held_reg[slot_reg]  <= 1'b0;
                            end
                        end
                        ACT_ACQUIRE: begin
                            if (ev_ok) begin
                                held_reg[slot_reg] <= 1'b1;
                            end
                        end
                        ACT_RELEASE: begin
                            if (ev_ok) begin
                                held_reg[slot_reg] <= 1'b0;
                                // a zero stamp means no usable start time
                                if (held_reg[slot_reg] && row_reg.acquired_at != '0) begin
                                    hold_reg  <= now_reg - row_reg.acquired_at;
                                    state_reg <= S_REL;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                S_REL: begin
                    state_reg <= S_IDLE;
                end
                S_SCAN: begin
                    if (valid_reg[idx_reg]) begin
                        held_cur_reg <= held_reg[idx_reg];
                        state_reg    <= S_LOAD;
                    end else begin
                        idx_reg <= idx_reg + SLOT_W'(1);
                    end
                end
                S_LOAD: begin
                    pct_num_reg <= DATA_W'(row_reg.con_count * PCT_SCALE);
                    limit_reg   <= DATA_W'(row_reg.max_hold * {24'd0, factor_reg});
                    dur_reg     <= now_reg - row_reg.acquired_at;
                    rem_reg     <= '0;
                    quo_reg     <= row_reg.hold_sum;
                    cnt_reg     <= '0;
                    state_reg   <= S_DIV_MEAN;
                end
                S_DIV_MEAN: begin
                    cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                    if (div_last) begin
                        mean_reg    <= (row_reg.acq_count == '0) ? '0 : quo_next;
                        suspect_reg <= held_cur_reg && (dur_reg > limit_reg)
                                       && (dur_reg > min_reg);
                        rem_reg     <= '0;
                        quo_reg     <= pct_num_reg;
                        state_reg   <= S_DIV_PCT;
                    end else begin
                        rem_reg <= rem_next;
                        quo_reg <= quo_next;
                    end
                end
                S_DIV_PCT: begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                    if (div_last) begin
                        pct_reg <= (row_reg.acq_count == '0 || row_reg.con_count == '0)
                                   ? '0 : quo_next;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        out_present_reg <= 1'b1;
                        out_last_reg    <= !more_after;
                        out_data_reg    <= {2'b00, suspect_reg, pct_reg, mean_reg,
                                            row_reg.max_hold, row_reg.con_count,
                                            row_reg.acq_count, held_cur_reg,
                                            SLOT_FIELD_W'(idx_reg)};
                        if (more_after) begin
                            idx_reg   <= idx_reg + SLOT_W'(1);
                            state_reg <= S_SCAN;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_EMPTY: begin
                    if (out_free) begin
                        out_present_reg <= 1'b0;
                        out_last_reg    <= 1'b1;
                        out_data_reg    <= '0;
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/lhst_checker.sv
// port-level checks for the lock hold statistics table, bound to the top level
module lhst_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [lhst_pkg::S_TUSER_W-1:0]  s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lhst_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [lhst_pkg::M_TUSER_W-1:0]  m_tuser,
    input logic                            m_tlast
);
    import lhst_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // only a report produces results
    a_no_result_from_event: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != ACT_REPORT |=> !$rose(m_tvalid))
        else $error("result after a non-report event");

    // no new item is taken while a report still has results to go
    a_busy_in_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a report");

    // the empty-table result is all zero and closes the report
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == '0)
        else $error("malformed empty-table result");

    // a suspect lock must be held
    a_suspect_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[165] |-> m_tdata[4])
        else $error("suspect flag on a lock that is not held");

endmodule

bind lock_hold_statistics_table lhst_checker u_lhst_checker (.*);
